// ===== design/hsv_to_rgb_converter_macros.svh =====
// Assertion macros shared by the HSV to RGB converter RTL.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Check a same-cycle implication, skipped while reset is held.
`define HTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent, skipped while reset is held.
`define HTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/htr_pkg.sv =====
// Widths, fixed-point constants and sector codes of the HSV to RGB converter.
// No dependencies.
package htr_pkg;

  localparam int HueW  = 15;
  localparam int SatW  = 9;
  localparam int LvlW  = 8;
  localparam int SecW  = 4;
  localparam int RemW  = 12;
  localparam int FracW = 16;
  localparam int OneW  = 25;

  localparam logic [SatW-1:0] SatOne  = 9'd256;
  localparam logic [OneW-1:0] ProdOne = 25'd16777216;
  localparam logic [FracW:0]  FracOne = 17'd65536;

  // 60 degrees is 15 * 256 hue units; hue[14:8] / 15 as (x * 137) >> 11
  localparam logic [7:0]  SecDiv     = 8'd15;
  localparam logic [7:0]  SecRecip   = 8'd137;
  localparam int          SecShift   = 11;
  // frac = rem * 256 / 15 as (rem * 1118482) >> 16
  localparam logic [20:0] FracRecip  = 21'd1118482;
  localparam int          FracShift  = 16;

  // Sector codes; 5 and the out-of-range sectors 6..8 share one mapping
  localparam logic [SecW-1:0] SecRedYel  = 4'd0;
  localparam logic [SecW-1:0] SecYelGrn  = 4'd1;
  localparam logic [SecW-1:0] SecGrnCyan = 4'd2;
  localparam logic [SecW-1:0] SecCyanBlu = 4'd3;
  localparam logic [SecW-1:0] SecBluMag  = 4'd4;

endpackage

// ===== design/hsv_to_rgb_converter.sv =====
// HSV to RGB converter: five-stage pipeline, one pixel per clock while the receiver is ready.
// Depends on htr_pkg and hsv_to_rgb_converter_macros.svh.
//
// Usage
//   Input beat : in_hue (1/64 degree), in_saturation (256 = 1.0), in_brightness.
//   Output beat: out_red, out_green, out_blue, truncated toward zero.
//   Both channels use valid/ready; a beat moves when valid and ready are high.
//   Throughput is one beat per cycle while out_ready is high, set by five
//   register stages with a valid bit each:
//     1 saturation clamp, sector by reciprocal multiply
//     2 remainder and in-sector fraction (reciprocal multiply)
//     3 s*f and s*(1-f) products, one-minus terms
//     4 multiply by value to form p, q, t
//     5 sector select / grey bypass into the output register
//   Each stage advances when it is empty or the next one advances, so a
//   stalled receiver holds only the filled stages; bubbles are squeezed out
//   and input keeps being taken until the pipe is full. Nothing is dropped
//   or repeated under stall.
//   Synchronous active-low reset empties all stages; payload is not reset.
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [htr_pkg::HueW-1:0]    in_hue,
  input  logic [htr_pkg::SatW-1:0]    in_saturation,
  input  logic [htr_pkg::LvlW-1:0]    in_brightness,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [htr_pkg::LvlW-1:0]    out_red,
  output logic [htr_pkg::LvlW-1:0]    out_green,
  output logic [htr_pkg::LvlW-1:0]    out_blue
);

  // Stage valid bits and enables
  logic [4:0] vld_r, vld_nxt;
  logic [4:0] en;

  always_comb begin
    en[4] = !vld_r[4] || out_ready;
    en[3] = !vld_r[3] || en[4];
    en[2] = !vld_r[2] || en[3];
    en[1] = !vld_r[1] || en[2];
    en[0] = !vld_r[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[4];

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    vld_nxt[1] = en[1] ? vld_r[0] : vld_r[1];
    vld_nxt[2] = en[2] ? vld_r[1] : vld_r[2];
    vld_nxt[3] = en[3] ? vld_r[2] : vld_r[3];
    vld_nxt[4] = en[4] ? vld_r[3] : vld_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------- Stage 1: clamp, grey flag, sector ----------------
  logic [htr_pkg::SatW-1:0] sat_nxt;
  logic [14:0]              secp;
  logic [htr_pkg::SecW-1:0] s1_sec_nxt;

  logic [6:0]               s1_hhi_r;
  logic [7:0]               s1_hlo_r;
  logic [htr_pkg::SecW-1:0] s1_sec_r;
  logic [htr_pkg::SatW-1:0] s1_sat_r;
  logic [htr_pkg::LvlW-1:0] s1_val_r;
  logic                     s1_grey_r;

  always_comb begin
    sat_nxt    = (in_saturation > htr_pkg::SatOne) ? htr_pkg::SatOne : in_saturation;
    secp       = 15'(in_hue[14:8]) * 15'(htr_pkg::SecRecip);
    s1_sec_nxt = secp[htr_pkg::SecShift +: htr_pkg::SecW];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_hhi_r  <= in_hue[14:8];
      s1_hlo_r  <= in_hue[7:0];
      s1_sec_r  <= s1_sec_nxt;
      s1_sat_r  <= sat_nxt;
      s1_val_r  <= in_brightness;
      s1_grey_r <= (in_saturation == '0);
    end
  end

  // ---------------- Stage 2: remainder and fraction ----------------
  logic [7:0]                s1_diff;
  logic [htr_pkg::RemW-1:0]  rem;
  logic [32:0]               fracp;

  logic [htr_pkg::FracW-1:0] s2_frac_r;
  logic [htr_pkg::SecW-1:0]  s2_sec_r;
  logic [htr_pkg::SatW-1:0]  s2_sat_r;
  logic [htr_pkg::LvlW-1:0]  s2_val_r;
  logic                      s2_grey_r;

  always_comb begin
    s1_diff = 8'(s1_hhi_r) - 8'(s1_sec_r) * htr_pkg::SecDiv;
    rem     = {s1_diff[3:0], s1_hlo_r};
    fracp   = 33'(rem) * 33'(htr_pkg::FracRecip);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_frac_r <= fracp[htr_pkg::FracShift +: htr_pkg::FracW];
      s2_sec_r  <= s1_sec_r;
      s2_sat_r  <= s1_sat_r;
      s2_val_r  <= s1_val_r;
      s2_grey_r <= s1_grey_r;
    end
  end

  // ---------------- Stage 3: one-minus terms ----------------
  logic [htr_pkg::OneW-1:0] sf;
  logic [25:0]              tf;

  logic [htr_pkg::OneW-1:0] s3_qm_r;
  logic [htr_pkg::OneW-1:0] s3_tm_r;
  logic [htr_pkg::SatW-1:0] s3_pm_r;
  logic [htr_pkg::SecW-1:0] s3_sec_r;
  logic [htr_pkg::LvlW-1:0] s3_val_r;
  logic                     s3_grey_r;

  always_comb begin
    sf = 25'(s2_sat_r) * 25'(s2_frac_r);
    tf = 26'(s2_sat_r) * 26'(htr_pkg::FracOne - 17'(s2_frac_r));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_qm_r   <= htr_pkg::ProdOne - sf;
      s3_tm_r   <= htr_pkg::ProdOne - tf[htr_pkg::OneW-1:0];
      s3_pm_r   <= htr_pkg::SatOne - s2_sat_r;
      s3_sec_r  <= s2_sec_r;
      s3_val_r  <= s2_val_r;
      s3_grey_r <= s2_grey_r;
    end
  end

  // ---------------- Stage 4: scale by value ----------------
  logic [32:0] qp, tp;
  logic [16:0] pp;

  logic [htr_pkg::LvlW-1:0] s4_p_r, s4_q_r, s4_t_r;
  logic [htr_pkg::SecW-1:0] s4_sec_r;
  logic [htr_pkg::LvlW-1:0] s4_val_r;
  logic                     s4_grey_r;

  always_comb begin
    qp = 33'(s3_val_r) * 33'(s3_qm_r);
    tp = 33'(s3_val_r) * 33'(s3_tm_r);
    pp = 17'(s3_val_r) * 17'(s3_pm_r);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_q_r    <= qp[31:24];
      s4_t_r    <= tp[31:24];
      s4_p_r    <= pp[15:8];
      s4_sec_r  <= s3_sec_r;
      s4_val_r  <= s3_val_r;
      s4_grey_r <= s3_grey_r;
    end
  end

  // ---------------- Stage 5: sector select ----------------
  logic [htr_pkg::LvlW-1:0] r_nxt, g_nxt, b_nxt;
  logic [htr_pkg::LvlW-1:0] out_red_r, out_green_r, out_blue_r;

  always_comb begin
    case (s4_sec_r)
      htr_pkg::SecRedYel: begin
        r_nxt = s4_val_r; g_nxt = s4_t_r;   b_nxt = s4_p_r;
      end
      htr_pkg::SecYelGrn: begin
        r_nxt = s4_q_r;   g_nxt = s4_val_r; b_nxt = s4_p_r;
      end
      htr_pkg::SecGrnCyan: begin
        r_nxt = s4_p_r;   g_nxt = s4_val_r; b_nxt = s4_t_r;
      end
      htr_pkg::SecCyanBlu: begin
        r_nxt = s4_p_r;   g_nxt = s4_q_r;   b_nxt = s4_val_r;
      end
      htr_pkg::SecBluMag: begin
        r_nxt = s4_t_r;   g_nxt = s4_p_r;   b_nxt = s4_val_r;
      end
      default: begin
        // magenta-to-red sector, and hue at or past 360 degrees
        r_nxt = s4_val_r; g_nxt = s4_p_r;   b_nxt = s4_q_r;
      end
    endcase
    if (s4_grey_r) begin
      r_nxt = s4_val_r;
      g_nxt = s4_val_r;
      b_nxt = s4_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      out_red_r   <= r_nxt;
      out_green_r <= g_nxt;
      out_blue_r  <= b_nxt;
    end
  end

  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // ---------------- Assertions ----------------
  `HTR_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, vld_r[0], "accepted beat not in stage 1")
  `HTR_ASSERT_NOW(a_sector_rem, vld_r[0], s1_diff < 8'(htr_pkg::SecDiv), "sector remainder out of range")
  `HTR_ASSERT_NOW(a_sat_clamp, vld_r[0], s1_sat_r <= htr_pkg::SatOne, "saturation not clamped")
  `HTR_ASSERT_NEXT(a_stall_hold, vld_r[3] && !en[3], vld_r[3] && $stable(s4_p_r), "stalled stage 4 lost data")
  `HTR_ASSERT_NEXT(a_grey_out, vld_r[3] && en[4] && s4_grey_r, (out_red == out_green) && (out_green == out_blue), "grey pixel not grey")

endmodule

// ===== sim/hsv_to_rgb_converter_tb.sv =====
// Self-checking testbench for the HSV to RGB converter pipeline.
// Depends on htr_pkg and the hsv_to_rgb_converter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Hue span of one 60 degree sector in 1/64 degree units
  localparam longint unsigned SectorSpan = 3840;
  localparam int LongHoldCycles = 100;
  localparam int RandomPixels = 1950;

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts the color of each accepted input beat and compares
  // output beats against the oldest prediction.
  // ---------------------------------------------------------------------------
  class rgb_scoreboard;
    typedef struct {
      logic [htr_pkg::HueW-1:0] hue;
      logic [htr_pkg::SatW-1:0] sat;
      logic [htr_pkg::LvlW-1:0] val;
      logic [htr_pkg::LvlW-1:0] red;
      logic [htr_pkg::LvlW-1:0] green;
      logic [htr_pkg::LvlW-1:0] blue;
    } pixel_t;

    pixel_t expected_q[$];
    int mismatches = 0;

    function pixel_t hsv_to_rgb(logic [htr_pkg::HueW-1:0] hue,
                                logic [htr_pkg::SatW-1:0] sat,
                                logic [htr_pkg::LvlW-1:0] val);
      pixel_t px;
      longint unsigned s, v, sector, rem, frac, one, p, q, t;
      px.hue = hue;
      px.sat = sat;
      px.val = val;
      v = val;
      // Clamp saturation above 1.0 to exactly 1.0
      s = (sat > htr_pkg::SatOne) ? longint'(htr_pkg::SatOne) : longint'(sat);
      if (s == 0) begin
        // Grey: all channels equal the value level
        px.red = val;
        px.green = val;
        px.blue = val;
        return px;
      end
      sector = hue / SectorSpan;
      rem = hue % SectorSpan;
      frac = (rem * longint'(htr_pkg::FracOne)) / SectorSpan;
      one = longint'(htr_pkg::ProdOne);
      p = (v * (longint'(htr_pkg::SatOne) - s)) >> 8;
      q = (v * (one - s * frac)) >> 24;
      t = (v * (one - s * (longint'(htr_pkg::FracOne) - frac))) >> 24;
      case (sector)
        htr_pkg::SecRedYel: begin
          px.red = v[7:0]; px.green = t[7:0]; px.blue = p[7:0];
        end
        htr_pkg::SecYelGrn: begin
          px.red = q[7:0]; px.green = v[7:0]; px.blue = p[7:0];
        end
        htr_pkg::SecGrnCyan: begin
          px.red = p[7:0]; px.green = v[7:0]; px.blue = t[7:0];
        end
        htr_pkg::SecCyanBlu: begin
          px.red = p[7:0]; px.green = q[7:0]; px.blue = v[7:0];
        end
        htr_pkg::SecBluMag: begin
          px.red = t[7:0]; px.green = p[7:0]; px.blue = v[7:0];
        end
        // Sector five and the hues at or past 360 degrees
        default: begin
          px.red = v[7:0]; px.green = p[7:0]; px.blue = q[7:0];
        end
      endcase
      return px;
    endfunction

    function void note_pixel(logic [htr_pkg::HueW-1:0] hue,
                             logic [htr_pkg::SatW-1:0] sat,
                             logic [htr_pkg::LvlW-1:0] val);
      expected_q.push_back(hsv_to_rgb(hue, sat, val));
    endfunction

    function void check_pixel(logic [htr_pkg::LvlW-1:0] red,
                              logic [htr_pkg::LvlW-1:0] green,
                              logic [htr_pkg::LvlW-1:0] blue);
      pixel_t px;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected output beat rgb=%0d/%0d/%0d", red, green, blue);
        return;
      end
      px = expected_q.pop_front();
      if (red !== px.red || green !== px.green || blue !== px.blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: mismatch hsv=%0d/%0d/%0d expected rgb=%0d/%0d/%0d got %0d/%0d/%0d",
                   px.hue, px.sat, px.val, px.red, px.green, px.blue, red, green, blue);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [htr_pkg::HueW-1:0] in_hue = '0;
  logic [htr_pkg::SatW-1:0] in_saturation = '0;
  logic [htr_pkg::LvlW-1:0] in_brightness = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [htr_pkg::LvlW-1:0] out_red;
  logic [htr_pkg::LvlW-1:0] out_green;
  logic [htr_pkg::LvlW-1:0] out_blue;

  // Set by the sender to request one long receiver hold-off
  bit long_hold_req = 1'b0;

  rgb_scoreboard sb = new();

  always #10 clk = ~clk;

  hsv_to_rgb_converter i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the edge, before any driver update
  // lands. Note the input beat first so a combinational input-to-output path
  // would still line up with its prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_pixel(in_hue, in_saturation, in_brightness);
      if (out_valid && out_ready)
        sb.check_pixel(out_red, out_green, out_blue);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks. Valid is raised for a beat and left high; only an idle
  // stretch or a drain lowers it, so back-to-back beats never toggle valid in one step.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic [htr_pkg::HueW-1:0] hue,
                            input logic [htr_pkg::SatW-1:0] sat,
                            input logic [htr_pkg::LvlW-1:0] val);
    in_valid <= 1'b1;
    in_hue <= hue;
    in_saturation <= sat;
    in_brightness <= val;
    @(posedge clk);
    // Hold the beat until the block takes it
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every predicted color has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Draw one random pixel, weighted toward sector edges, grey, full and
  // over-range saturation, and hues past 360 degrees.
  task automatic pick_pixel(output logic [htr_pkg::HueW-1:0] hue,
                            output logic [htr_pkg::SatW-1:0] sat,
                            output logic [htr_pkg::LvlW-1:0] val);
    int sel;
    int base;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      hue = 15'($urandom_range(23040, 32767));
    end else if (sel < 22) begin
      base = $urandom_range(0, 8) * 3840;
      case ($urandom_range(0, 2))
        0: base = base;
        1: base = base + 1;
        default: base = base + 3839;
      endcase
      hue = (base > 32767) ? 15'd32767 : base[htr_pkg::HueW-1:0];
    end else begin
      hue = 15'($urandom_range(0, 23039));
    end
    sel = $urandom_range(0, 99);
    if (sel < 8) sat = '0;
    else if (sel < 16) sat = htr_pkg::SatOne;
    else if (sel < 26) sat = 9'($urandom_range(257, 511));
    else if (sel < 30) sat = 9'd1;
    else sat = 9'($urandom_range(1, 255));
    sel = $urandom_range(0, 99);
    if (sel < 5) val = '0;
    else if (sel < 10) val = 8'd255;
    else val = 8'($urandom_range(0, 255));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall on patterns of its own, switching pattern every segment.
  // On request, hold off for a long stretch so the pipe fills and in_ready
  // drops while the sender keeps offering beats.
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    int k;
    int held;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 120);
      for (k = 0; k < span; k++) begin
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          out_ready <= 1'b0;
          for (held = 0; held < LongHoldCycles; held++) @(posedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (k % 3 == 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed corners, random bursts, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    logic [htr_pkg::HueW-1:0] hue;
    logic [htr_pkg::SatW-1:0] sat;
    logic [htr_pkg::LvlW-1:0] val;
    int sent;
    int burst;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes and grey
    send_pixel(15'd0, 9'd0, 8'd0);
    send_pixel(15'd0, 9'd0, 8'd255);
    send_pixel(15'd12345, 9'd0, 8'd77);
    send_pixel(15'd0, htr_pkg::SatOne, 8'd255);
    send_pixel(15'd32767, 9'd511, 8'd255);
    send_pixel(15'd32767, 9'd0, 8'd128);
    // Saturation just above and below 1.0, and the smallest nonzero one
    send_pixel(15'd1000, 9'd257, 8'd200);
    send_pixel(15'd1000, 9'd255, 8'd200);
    send_pixel(15'd1000, 9'd1, 8'd200);
    idle_sender(3);
    // Sector starts and ends, at several saturation levels
    send_pixel(15'd3839, htr_pkg::SatOne, 8'd255);
    send_pixel(15'd3840, htr_pkg::SatOne, 8'd255);
    send_pixel(15'd7679, 9'd200, 8'd255);
    send_pixel(15'd7680, 9'd200, 8'd255);
    send_pixel(15'd11520, 9'd128, 8'd180);
    send_pixel(15'd15359, 9'd128, 8'd180);
    send_pixel(15'd15360, 9'd64, 8'd99);
    send_pixel(15'd19200, 9'd300, 8'd255);
    send_pixel(15'd23039, htr_pkg::SatOne, 8'd255);
    idle_sender(2);
    // Hues at or past 360 degrees fall back to the last sector's mapping, then in-range pixels
    send_pixel(15'd23040, htr_pkg::SatOne, 8'd255);
    send_pixel(15'd26880, 9'd180, 8'd240);
    send_pixel(15'd30720, 9'd90, 8'd31);
    send_pixel(15'd16384, 9'd170, 8'd85);
    send_pixel(15'd5000, htr_pkg::SatOne, 8'd1);
    send_pixel(15'd20000, 9'd400, 8'd0);
    wait_drained();

    // Fill the pipe against a long receiver hold-off: no gaps here
    long_hold_req = 1'b1;
    for (sent = 0; sent < 40; sent++) begin
      pick_pixel(hue, sat, val);
      send_pixel(hue, sat, val);
    end

    // Random bursts with random gaps; some gaps are zero for unbroken stretches
    while (sent < RandomPixels) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < RandomPixels) begin
        pick_pixel(hue, sat, val);
        send_pixel(hue, sat, val);
        burst--;
        sent++;
      end
      if (sent == 1000) wait_drained();
      else if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end

    wait_drained();
    // Let any stray beat surface before the verdict
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // Run limit: far beyond the slowest correct run
  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
